/* design/dmmd_pkg.sv */
// Shared types, codes and segment table of the meter packet decoder.
`default_nettype none

package dmmd_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int SEG_ENTRIES = 23;

   localparam logic [7:0] SEG_MASK     = 8'hF7;
   localparam logic [7:0] CHECK_OFFSET = 8'd57;
   localparam logic [7:0] MODE_MAX     = 8'd25;

   // Overload pattern on bytes 3, 4 and 5 after masking.
   localparam logic [7:0] OVF_BYTE3 = 8'h00;
   localparam logic [7:0] OVF_BYTE4 = 8'h27;
   localparam logic [7:0] OVF_BYTE5 = 8'hD7;

   localparam logic [3:0] ERR_OK        = 4'd0;
   localparam logic [3:0] ERR_MODE      = 4'd1;
   localparam logic [3:0] ERR_UNIT_MODE = 4'd2;
   localparam logic [3:0] ERR_UNITS     = 4'd3;
   localparam logic [3:0] ERR_MULTS     = 4'd4;
   localparam logic [3:0] ERR_MINMAX    = 4'd5;
   localparam logic [3:0] ERR_POINTS    = 4'd6;
   localparam logic [3:0] ERR_SERIAL    = 4'd7;
   localparam logic [3:0] ERR_CHECKSUM  = 4'd8;
   localparam logic [3:0] ERR_NO_UNIT   = 4'd9;

   localparam logic [3:0] UNIT_F    = 4'd0;
   localparam logic [3:0] UNIT_A    = 4'd1;
   localparam logic [3:0] UNIT_OHM  = 4'd2;
   localparam logic [3:0] UNIT_HZ   = 4'd3;
   localparam logic [3:0] UNIT_V    = 4'd4;
   localparam logic [3:0] UNIT_PCT  = 4'd5;
   localparam logic [3:0] UNIT_DBM  = 4'd6;
   localparam logic [3:0] UNIT_S    = 4'd7;
   localparam logic [3:0] UNIT_HFE  = 4'd8;
   localparam logic [3:0] UNIT_NONE = 4'd9;

   localparam logic [2:0] PREFIX_NONE  = 3'd0;
   localparam logic [2:0] PREFIX_NANO  = 3'd1;
   localparam logic [2:0] PREFIX_MICRO = 3'd2;
   localparam logic [2:0] PREFIX_MILLI = 3'd3;
   localparam logic [2:0] PREFIX_KILO  = 3'd4;
   localparam logic [2:0] PREFIX_MEGA  = 3'd5;

   localparam logic [4:0] SEG_UNKNOWN = 5'd23;

   // Patterns for 0..9 F P E C L H I h r t n - blank.
   localparam logic [7:0] SEG_PATTERNS [SEG_ENTRIES] = '{
      8'hD7, 8'h50, 8'hB5, 8'hF1, 8'h72, 8'hE3, 8'hE7, 8'h51, 8'hF7, 8'hF3,
      8'h27, 8'h37, 8'hA7, 8'h87, 8'h86, 8'h76, 8'h06, 8'h66, 8'h24, 8'hA6,
      8'h64, 8'h20, 8'h00
   };

   typedef logic [FRAME_BYTES-1:0][7:0] window_type;

   typedef struct packed {
      logic       valid;
      window_type window;
   } frame_beat_type;

   typedef struct packed {
      logic [3:0] error_code;
      logic [7:0] meter_mode;
      logic       overflow;
      logic       negative;
      logic [4:0] digit_3;
      logic [4:0] digit_2;
      logic [4:0] digit_1;
      logic [4:0] digit_0;
      logic [1:0] point_position;
      logic [3:0] unit_code;
      logic [2:0] prefix_code;
      logic [4:0] status_flags;
   } result_type;

endpackage

`default_nettype wire

/* design/dmmd_channels.sv */
// Valid/ready channel interfaces for meter bytes and decoded results.
`default_nettype none

interface dmmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dmmd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] error_code;
   logic [7:0] meter_mode;
   logic       overflow;
   logic       negative;
   logic [4:0] digit_3;
   logic [4:0] digit_2;
   logic [4:0] digit_1;
   logic [4:0] digit_0;
   logic [1:0] point_position;
   logic [3:0] unit_code;
   logic [2:0] prefix_code;
   logic [4:0] status_flags;

   modport source (output valid, output error_code, output meter_mode, output overflow,
                   output negative, output digit_3, output digit_2, output digit_1,
                   output digit_0, output point_position, output unit_code,
                   output prefix_code, output status_flags, input ready);
   modport sink   (input valid, input error_code, input meter_mode, input overflow,
                   input negative, input digit_3, input digit_2, input digit_1,
                   input digit_0, input point_position, input unit_code,
                   input prefix_code, input status_flags, output ready);
endinterface

`default_nettype wire

/* design/dmmd_front.sv */
// Front end: byte shift window and fill count, emits full windows.
`default_nettype none

module dmmd_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     byte_valid,
   output logic                    byte_ready,
   input  wire  [7:0]              rx_byte,
   input  wire                     queue_full,
   output dmmd_pkg::frame_beat_type push
);
   import dmmd_pkg::*;

   localparam logic [3:0] FILL_FULL = 4'(FRAME_BYTES);
   localparam logic [3:0] FILL_LAST = 4'(FRAME_BYTES - 1);

   window_type window_ff, window_in;
   logic [3:0] fill_ff, fill_in;
   logic       accept;
   logic       emits;

   // A byte that completes or slides a full window needs queue room.
   assign emits      = (fill_ff >= FILL_LAST);
   assign byte_ready = !(emits && queue_full);
   assign accept     = byte_valid && byte_ready;

   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (accept) begin
         window_in = {rx_byte, window_ff[FRAME_BYTES-1:1]};
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + 4'd1;
         end
      end
   end

   assign push.valid  = accept && emits;
   assign push.window = {rx_byte, window_ff[FRAME_BYTES-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

/* design/dmmd_queue.sv */
// Two-entry window queue between the front end and the decoder.
`default_nettype none

module dmmd_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  dmmd_pkg::frame_beat_type push,
   output logic                     full,
   output logic                     head_valid,
   output dmmd_pkg::window_type     head_window,
   input  wire                      pop
);
   import dmmd_pkg::*;

   window_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full        = (count_ff == 2'd2);
   assign head_valid  = (count_ff != 2'd0);
   assign head_window = slot_ff[rd_ptr_ff];
   assign do_push     = push.valid && !full;
   assign do_pop      = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.window;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* design/dmmd_back.sv */
// Back end: checks and decodes one window into a registered result.
`default_nettype none

module dmmd_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  head_valid,
   input  dmmd_pkg::window_type head_window,
   output logic                 pop,
   output logic                 result_valid,
   output dmmd_pkg::result_type result,
   input  wire                  result_ready
);
   import dmmd_pkg::*;

   function automatic logic [4:0] seg_code(logic [7:0] b);
      logic [7:0] m;
      logic [4:0] code;
      m    = b & SEG_MASK;
      code = SEG_UNKNOWN;
      for (int i = SEG_ENTRIES - 1; i >= 0; i--) begin
         if (SEG_PATTERNS[i] == m) begin
            code = 5'(i);
         end
      end
      return code;
   endfunction

   function automatic logic [3:0] check_window(window_type w);
      logic [7:0] mode, b1, b2, sum;
      logic [3:0] units;
      logic [2:0] mults;
      logic [1:0] mm, dp;
      mode  = w[0];
      b1    = w[1];
      b2    = w[2];
      units = '0;
      mults = '0;
      mm    = '0;
      dp    = '0;
      if (mode > MODE_MAX) return ERR_MODE;

      if (b1[0]) mults = mults + 3'd1;
      if (b1[1]) begin
         units = units + 4'd1;
         if (!(mode == 8'd0 || mode == 8'd1 || mode == 8'd19 || mode == 8'd22))
            return ERR_UNIT_MODE;
      end
      if (b1[2]) begin
         units = units + 4'd1;
         if (mode < 8'd2 || mode > 8'd7) return ERR_UNIT_MODE;
      end
      if (b1[3]) begin
         units = units + 4'd1;
         if (mode != 8'd9) return ERR_UNIT_MODE;
      end
      if (b1[4]) mults = mults + 3'd1;
      if (b1[5]) mults = mults + 3'd1;
      if (b1[6]) begin
         units = units + 4'd1;
         if (mode != 8'd8) return ERR_UNIT_MODE;
      end
      if (b1[7]) begin
         units = units + 4'd1;
         if (mode < 8'd10 || mode > 8'd12) return ERR_UNIT_MODE;
      end
      if (units > 4'd1) return ERR_UNITS;
      if (mults > 3'd1) return ERR_MULTS;

      // Modes with a fixed unit require that unit bit.
      if (mode < 8'd2) begin
         if (!b1[1]) return ERR_UNIT_MODE;
      end else if (mode < 8'd8) begin
         if (!b1[2]) return ERR_UNIT_MODE;
      end else if (mode < 8'd9) begin
         if (!b1[6]) return ERR_UNIT_MODE;
      end else if (mode < 8'd10) begin
         if (!b1[3]) return ERR_UNIT_MODE;
      end else if (mode < 8'd13) begin
         if (!b1[7]) return ERR_UNIT_MODE;
      end

      if (b2[0]) mm = mm + 2'd1;
      if (b2[1]) mm = mm + 2'd1;
      if (b2[2]) begin
         units = units + 4'd1;
         if (mode != 8'd21) return ERR_UNIT_MODE;
      end
      if (b2[4]) begin
         units = units + 4'd1;
         if (mode < 8'd16 || mode > 8'd18) return ERR_UNIT_MODE;
      end
      if (b2[5]) begin
         units = units + 4'd1;
         if (mode != 8'd23) return ERR_UNIT_MODE;
      end
      if (b2[6]) mults = mults + 3'd1;
      if (b2[7]) mults = mults + 3'd1;
      if (units > 4'd1) return ERR_UNITS;
      if (mults > 3'd1) return ERR_MULTS;
      if (mm > 2'd1) return ERR_MINMAX;

      for (int i = 3; i <= 5; i++) begin
         if (w[i][3]) dp = dp + 2'd1;
      end
      if (dp > 2'd1) return ERR_POINTS;

      if (w[6][3]) mm = mm + 2'd1;
      if (mm > 2'd1) return ERR_MINMAX;

      if (!w[7][1]) return ERR_SERIAL;

      sum = CHECK_OFFSET;
      for (int i = 0; i < 8; i++) begin
         sum = sum + w[i];
      end
      if (sum != w[8]) return ERR_CHECKSUM;
      return ERR_OK;
   endfunction

   function automatic result_type decode(window_type w);
      result_type r;
      logic [3:0] err;
      logic [7:0] b1, b2, b7;
      logic       ovf;
      b1  = w[1];
      b2  = w[2];
      b7  = w[7];
      r   = '0;
      err = check_window(w);
      r.meter_mode = w[0];
      if (err != ERR_OK) begin
         r.error_code = err;
         return r;
      end

      ovf = ((w[3] & SEG_MASK) == OVF_BYTE3) && ((w[4] & SEG_MASK) == OVF_BYTE4) &&
            ((w[5] & SEG_MASK) == OVF_BYTE5);

      if (b1[3])      r.unit_code = UNIT_F;
      else if (b1[2]) r.unit_code = UNIT_A;
      else if (b1[6]) r.unit_code = UNIT_OHM;
      else if (b1[7]) r.unit_code = UNIT_HZ;
      else if (b1[1]) r.unit_code = UNIT_V;
      else if (b2[3]) r.unit_code = UNIT_PCT;
      else if (b2[5]) r.unit_code = UNIT_DBM;
      else if (b2[4]) r.unit_code = UNIT_S;
      else if (b2[2]) r.unit_code = UNIT_HFE;
      else            r.unit_code = UNIT_NONE;

      if (b2[6])      r.prefix_code = PREFIX_NANO;
      else if (b2[7]) r.prefix_code = PREFIX_MICRO;
      else if (b1[0]) r.prefix_code = PREFIX_MILLI;
      else if (b1[5]) r.prefix_code = PREFIX_KILO;
      else if (b1[4]) r.prefix_code = PREFIX_MEGA;
      else            r.prefix_code = PREFIX_NONE;

      r.error_code = (r.unit_code == UNIT_NONE) ? ERR_NO_UNIT : ERR_OK;
      r.overflow   = ovf;
      // Drop the sign on an overload display.
      r.negative   = ovf ? 1'b0 : b7[3];
      r.digit_3    = seg_code(w[6]);
      r.digit_2    = seg_code(w[5]);
      r.digit_1    = seg_code(w[4]);
      r.digit_0    = seg_code(w[3]);
      r.point_position = w[3][3] ? 2'd3 : w[4][3] ? 2'd2 : w[5][3] ? 2'd1 : 2'd0;
      r.status_flags   = {b7[7], b7[6], b7[2], b7[4], b7[0]};
      return r;
   endfunction

   result_type result_ff, result_in;
   logic       valid_ff, valid_in;

   // Advance when the output register is empty or being drained.
   assign pop = head_valid && (!valid_ff || result_ready);

   always_comb begin
      result_in = result_ff;
      valid_in  = valid_ff;
      if (result_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         result_in = decode(head_window);
         valid_in  = 1'b1;
      end
   end

   assign result_valid = valid_ff;
   assign result       = result_ff;

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

/* design/dmm_segment_packet_decoder.sv */
// Top level of the segment-display meter packet decoder.
//
// req carries one raw meter byte per beat (rx_byte); rsp carries one decoded
// result per beat. Bytes shift into a nine-byte window; the first eight bytes
// after reset give no result, and from the ninth on every byte gives exactly
// one result for the window ending at that byte.
// A front end holds the window and pushes each full window into a two-entry
// queue; the back end checks and decodes the queue head into an output
// register. A window is held in the queue before its result is registered.
// Throughput is one byte per cycle while rsp does not stall, as the decode
// is combinational between the queue head and the output register.
// When rsp stalls, results pile up in the output register and the queue;
// req.ready falls only once both queue entries are taken and the incoming
// byte would produce a result. Results are never dropped.
// Synchronous reset empties the window, the fill count, the queue and the
// output register; the block accepts bytes in the first cycle after reset.
`default_nettype none

module dmm_segment_packet_decoder (
   input wire              clock,
   input wire              reset,
   dmmd_req_if.sink        req,
   dmmd_rsp_if.source      rsp
);
   import dmmd_pkg::*;

   frame_beat_type push;
   window_type     head_window;
   result_type     result;
   logic           queue_full;
   logic           head_valid;
   logic           pop;
   logic           result_valid;

   dmmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req.valid),
      .byte_ready (req.ready),
      .rx_byte    (req.rx_byte),
      .queue_full (queue_full),
      .push       (push)
   );

   dmmd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (queue_full),
      .head_valid  (head_valid),
      .head_window (head_window),
      .pop         (pop)
   );

   dmmd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_window  (head_window),
      .pop          (pop),
      .result_valid (result_valid),
      .result       (result),
      .result_ready (rsp.ready)
   );

   assign rsp.valid          = result_valid;
   assign rsp.error_code     = result.error_code;
   assign rsp.meter_mode     = result.meter_mode;
   assign rsp.overflow       = result.overflow;
   assign rsp.negative       = result.negative;
   assign rsp.digit_3        = result.digit_3;
   assign rsp.digit_2        = result.digit_2;
   assign rsp.digit_1        = result.digit_1;
   assign rsp.digit_0        = result.digit_0;
   assign rsp.point_position = result.point_position;
   assign rsp.unit_code      = result.unit_code;
   assign rsp.prefix_code    = result.prefix_code;
   assign rsp.status_flags   = result.status_flags;

endmodule

`default_nettype wire
